[hw/rtl/irn_pkg.sv]
package irn_pkg;

  typedef logic [11:0] value_t;
  typedef logic [2:0]  sym_t;
  typedef logic [3:0]  pc_t;

  // roman symbol codes, the five and ten symbols of a place are unit+1 and unit+2
  localparam sym_t SYM_I = 3'd0;
  localparam sym_t SYM_X = 3'd2;
  localparam sym_t SYM_C = 3'd4;
  localparam sym_t SYM_M = 3'd6;

  localparam value_t MAX_VALUE = 12'd3999;
  localparam value_t NEVER     = 12'hFFF;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_ERR   = 3'd1,
    OP_MAIN  = 3'd2,
    OP_NINE2 = 3'd3,
    OP_FOUR2 = 3'd4
  } op_e;

  // microprogram step addresses
  localparam pc_t PC_IDLE = 4'd0;
  localparam pc_t PC_ERR  = 4'd1;
  localparam pc_t PC_M    = 4'd2;
  localparam pc_t PC_C    = 4'd3;
  localparam pc_t PC_C9   = 4'd4;
  localparam pc_t PC_C4   = 4'd5;
  localparam pc_t PC_X    = 4'd6;
  localparam pc_t PC_X9   = 4'd7;
  localparam pc_t PC_X4   = 4'd8;
  localparam pc_t PC_I    = 4'd9;
  localparam pc_t PC_I9   = 4'd10;
  localparam pc_t PC_I4   = 4'd11;

  typedef struct packed {
    op_e    op;
    sym_t   unit;
    value_t w1;
    value_t w4;
    value_t w5;
    value_t w9;
    pc_t    jmp_nine;
    pc_t    jmp_four;
  } uword_t;

  function automatic uword_t urow(op_e op, sym_t unit, value_t w1, value_t w4,
                                  value_t w5, value_t w9, pc_t j9, pc_t j4);
    uword_t w;
    w.op       = op;
    w.unit     = unit;
    w.w1       = w1;
    w.w4       = w4;
    w.w5       = w5;
    w.w9       = w9;
    w.jmp_nine = j9;
    w.jmp_four = j4;
    return w;
  endfunction

  // control store
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      PC_ERR: w = urow(OP_ERR, SYM_I, NEVER, NEVER, NEVER, NEVER, PC_IDLE, PC_IDLE);
      PC_M:   w = urow(OP_MAIN, SYM_M, 12'd1000, NEVER, NEVER, NEVER, PC_IDLE, PC_IDLE);
      PC_C:   w = urow(OP_MAIN, SYM_C, 12'd100, 12'd400, 12'd500, 12'd900, PC_C9, PC_C4);
      PC_C9:  w = urow(OP_NINE2, SYM_C, 12'd100, 12'd400, 12'd500, 12'd900, PC_C9, PC_C4);
      PC_C4:  w = urow(OP_FOUR2, SYM_C, 12'd100, 12'd400, 12'd500, 12'd900, PC_C9, PC_C4);
      PC_X:   w = urow(OP_MAIN, SYM_X, 12'd10, 12'd40, 12'd50, 12'd90, PC_X9, PC_X4);
      PC_X9:  w = urow(OP_NINE2, SYM_X, 12'd10, 12'd40, 12'd50, 12'd90, PC_X9, PC_X4);
      PC_X4:  w = urow(OP_FOUR2, SYM_X, 12'd10, 12'd40, 12'd50, 12'd90, PC_X9, PC_X4);
      PC_I:   w = urow(OP_MAIN, SYM_I, 12'd1, 12'd4, 12'd5, 12'd9, PC_I9, PC_I4);
      PC_I9:  w = urow(OP_NINE2, SYM_I, 12'd1, 12'd4, 12'd5, 12'd9, PC_I9, PC_I4);
      PC_I4:  w = urow(OP_FOUR2, SYM_I, 12'd1, 12'd4, 12'd5, 12'd9, PC_I9, PC_I4);
      default: w = urow(OP_IDLE, SYM_I, NEVER, NEVER, NEVER, NEVER, PC_IDLE, PC_IDLE);
    endcase
    return w;
  endfunction

  // first decimal place that still holds a nonzero digit
  function automatic pc_t place_pc(value_t r);
    pc_t pc;
    priority if (r == '0) begin
      pc = PC_IDLE;
    end else if (r >= 12'd1000) begin
      pc = PC_M;
    end else if (r >= 12'd100) begin
      pc = PC_C;
    end else if (r >= 12'd10) begin
      pc = PC_X;
    end else begin
      pc = PC_I;
    end
    return pc;
  endfunction

endpackage

[hw/rtl/integer_to_roman_numeral_unit.sv]
// integer to roman numeral unit
//
// a transaction is taken at a rising edge with start high and busy low; value_i
// is the binary integer (1 to 3999 is valid). the numeral leaves one symbol per
// cycle, most significant first, each on symbol_o for one cycle with strobe_o
// high; last_o marks the final symbol of the transaction. a value of 0 or above
// 3999 gives one result with error_o and last_o set and symbol I.
//
// the accepting edge loads the first step into the program counter, and that
// step's symbol is registered onto symbol_o with strobe_o. a small microprogram
// steps a remainder register through the places and emits exactly one symbol
// per step, skipping zero digits; a numeral has 1 to 15 symbols. busy drops as
// the last symbol shows, and the next transaction can be taken at the edge
// that takes that last symbol.
//
// reset returns the sequencer to idle and clears the strobe; nothing else is
// kept between transactions. the receiver cannot stall: every strobed result
// is taken in its cycle.
module integer_to_roman_numeral_unit
  import irn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] value_i,
  output logic        strobe_o,
  output logic [2:0]  symbol_o,
  output logic        last_o,
  output logic        error_o
);

  pc_t    pc_q, pc_d;
  value_t r_q, r_d;
  logic   strobe_q, strobe_d;
  sym_t   symbol_q, symbol_d;
  logic   last_q, last_d;
  logic   error_q, error_d;
  uword_t uw;
  logic   advance;

  assign uw   = ucode(pc_q);
  assign busy = (pc_q != PC_IDLE);

  always_comb begin
    pc_d     = pc_q;
    r_d      = r_q;
    strobe_d = 1'b0;
    symbol_d = symbol_q;
    last_d   = 1'b0;
    error_d  = 1'b0;
    advance  = 1'b0;
    unique case (uw.op)
      OP_IDLE: begin
        if (start) begin
          r_d = value_i;
          if (value_i == '0 || value_i > MAX_VALUE) begin
            pc_d = PC_ERR;
          end else begin
            pc_d = place_pc(value_i);
          end
        end
      end
      OP_ERR: begin
        strobe_d = 1'b1;
        symbol_d = SYM_I;
        last_d   = 1'b1;
        error_d  = 1'b1;
        pc_d     = PC_IDLE;
      end
      OP_MAIN: begin
        strobe_d = 1'b1;
        priority if (r_q >= uw.w9) begin
          // first half of a subtractive nine
          symbol_d = uw.unit;
          pc_d     = uw.jmp_nine;
        end else if (r_q >= uw.w5) begin
          symbol_d = uw.unit + 3'd1;
          r_d      = r_q - uw.w5;
          advance  = 1'b1;
        end else if (r_q >= uw.w4) begin
          symbol_d = uw.unit;
          pc_d     = uw.jmp_four;
        end else begin
          symbol_d = uw.unit;
          r_d      = r_q - uw.w1;
          advance  = 1'b1;
        end
      end
      OP_NINE2: begin
        strobe_d = 1'b1;
        symbol_d = uw.unit + 3'd2;
        r_d      = r_q - uw.w9;
        advance  = 1'b1;
      end
      OP_FOUR2: begin
        strobe_d = 1'b1;
        symbol_d = uw.unit + 3'd1;
        r_d      = r_q - uw.w4;
        advance  = 1'b1;
      end
    endcase
    if (advance) begin
      // jump straight to the next nonzero place, or finish
      pc_d   = place_pc(r_d);
      last_d = (r_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= PC_IDLE;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      error_q  <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
      error_q  <= error_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    symbol_q <= symbol_d;
  end

  assign strobe_o = strobe_q;
  assign symbol_o = symbol_q;
  assign last_o   = last_q;
  assign error_o  = error_q;

  // symbols of one transaction leave back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("gap inside a numeral");

  // an error result stands alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && error_o |-> last_o && symbol_o == SYM_I)
    else $error("malformed error result");

  // the final symbol shows only once the sequencer is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> !busy)
    else $error("last symbol while still busy");

  // a newly taken transaction has nothing in flight behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !strobe_o && busy)
    else $error("stale result after accept");

endmodule

[sim/integer_to_roman_numeral_unit_tb.sv]
module integer_to_roman_numeral_unit_tb;
  import irn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 150000;
  localparam int unsigned RANDOM_ITEMS = 355;
  localparam int unsigned MAX_IDLE = 17;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int N_DIRECTED = 25;

  // five symbols of each place sit one above the unit symbol
  localparam sym_t SYM_V = SYM_I + 3'd1;
  localparam sym_t SYM_L = SYM_X + 3'd1;
  localparam sym_t SYM_D = SYM_C + 3'd1;

  typedef struct packed {
    sym_t symbol;
    logic last;
    logic error;
  } numeral_sym_t;

  // an empty spelling means the row is checked against the predictor, "!" is an error result
  typedef struct {
    value_t value;
    string  spelled;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  value_t      value_i = '0;
  logic        strobe_o;
  logic [2:0]  symbol_o;
  logic        last_o;
  logic        error_o;

  numeral_sym_t numeral_q[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{12'd0,    "!"},
    '{12'd4000, "!"},
    '{12'd4095, "!"},
    '{12'd1,    "I"},
    '{12'd3999, "MMMCMXCIX"},
    '{12'd3888, "MMMDCCCLXXXVIII"},
    '{12'd1000, "M"},
    '{12'd3000, "MMM"},
    '{12'd2048, ""},
    '{12'd4,    ""},
    '{12'd9,    ""},
    '{12'd5,    ""},
    '{12'd8,    ""},
    '{12'd40,   ""},
    '{12'd90,   ""},
    '{12'd400,  ""},
    '{12'd900,  ""},
    '{12'd500,  ""},
    '{12'd50,   ""},
    '{12'd10,   ""},
    '{12'd100,  ""},
    '{12'd1994, ""},
    '{12'd2444, ""},
    '{12'd1666, ""},
    '{12'd3449, ""}
  };

  integer_to_roman_numeral_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .value_i (value_i),
    .strobe_o(strobe_o),
    .symbol_o(symbol_o),
    .last_o  (last_o),
    .error_o (error_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic void push_symbols(input sym_t syms[$]);
    foreach (syms[i]) begin
      numeral_q.push_back('{symbol: syms[i], last: (i == syms.size() - 1), error: 1'b0});
    end
  endfunction

  function automatic void predict_numeral(input value_t v);
    sym_t        syms[$];
    sym_t        unit;
    int unsigned rest;
    int unsigned digit;
    int unsigned scale;
    if (v == '0 || v > MAX_VALUE) begin
      numeral_q.push_back('{symbol: SYM_I, last: 1'b1, error: 1'b1});
      return;
    end
    rest = v;
    repeat (rest / 1000) syms.push_back(SYM_M);
    rest = rest % 1000;
    scale = 100;
    unit = SYM_C;
    repeat (3) begin
      digit = rest / scale;
      rest = rest % scale;
      if (digit == 9) begin
        syms.push_back(unit);
        syms.push_back(unit + 3'd2);
      end else if (digit >= 5) begin
        syms.push_back(unit + 3'd1);
        repeat (digit - 5) syms.push_back(unit);
      end else if (digit == 4) begin
        syms.push_back(unit);
        syms.push_back(unit + 3'd1);
      end else begin
        repeat (digit) syms.push_back(unit);
      end
      scale = scale / 10;
      unit = unit - 3'd2;
    end
    push_symbols(syms);
  endfunction

  function automatic void push_spelled(input string spelled);
    sym_t syms[$];
    if (spelled == "!") begin
      numeral_q.push_back('{symbol: SYM_I, last: 1'b1, error: 1'b1});
      return;
    end
    for (int i = 0; i < spelled.len(); i++) begin
      case (spelled[i])
        "I": syms.push_back(SYM_I);
        "V": syms.push_back(SYM_V);
        "X": syms.push_back(SYM_X);
        "L": syms.push_back(SYM_L);
        "C": syms.push_back(SYM_C);
        "D": syms.push_back(SYM_D);
        default: syms.push_back(SYM_M);
      endcase
    end
    push_symbols(syms);
  endfunction

  // hold start high until the block takes the transaction, then log what it owes
  task automatic send_value(input value_t v, input string spelled, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    value_i <= v;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (spelled.len() != 0) begin
      push_spelled(spelled);
    end else begin
      predict_numeral(v);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (numeral_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic value_t random_value();
    int unsigned pick;
    int unsigned digits[4];
    int unsigned v;
    pick = $urandom_range(0, 99);
    if (pick < 3) return '0;
    if (pick < 10) return value_t'($urandom_range(4000, 4095));
    if (pick < 40) begin
      // lean on the digits that take the subtractive pairs or the longest runs, and on zeros
      foreach (digits[i]) begin
        case ($urandom_range(0, 4))
          0: digits[i] = 4;
          1: digits[i] = 9;
          2: digits[i] = 8;
          3: digits[i] = 0;
          default: digits[i] = $urandom_range(0, 9);
        endcase
      end
      v = (digits[0] % 4) * 1000 + digits[1] * 100 + digits[2] * 10 + digits[3];
      if (v == 0) v = 3888;
      return value_t'(v);
    end
    return value_t'($urandom_range(1, 3999));
  endfunction

  always @(posedge clk_i) begin : result_check
    numeral_sym_t want;
    if (rst_ni && strobe_o === 1'b1) begin
      if (numeral_q.size() == 0) begin
        $display("%0t: result with nothing pending: symbol %0d last %0b error %0b",
                 $time, symbol_o, last_o, error_o);
        mismatches++;
      end else begin
        want = numeral_q.pop_front();
        if (symbol_o !== want.symbol) begin
          $display("%0t: symbol expected %0d actual %0d", $time, want.symbol, symbol_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
          mismatches++;
        end
        if (error_o !== want.error) begin
          $display("%0t: error expected %0b actual %0b", $time, want.error, error_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("integer_to_roman_numeral_unit_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    bit          no_idle;
    int unsigned gap;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      gap = (i < 8) ? 0 : $urandom_range(0, MAX_IDLE);
      send_value(directed_rows[i].value, directed_rows[i].spelled, gap);
    end
    drain_results();

    no_idle = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 49) == 0) drain_results();
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      send_value(random_value(), "", gap);
    end
    start <= 1'b0;

    while (numeral_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("integer_to_roman_numeral_unit_tb: done, clean");
    end else begin
      $display("integer_to_roman_numeral_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/irn_pkg.sv
hw/rtl/integer_to_roman_numeral_unit.sv
sim/integer_to_roman_numeral_unit_tb.sv
